// ===== sv/mono_page_frame_to_rgb565_upscaler_assert.svh =====
// Assertion macros used by the upscaler top-level RTL file.
`ifndef MONO_PAGE_FRAME_TO_RGB565_UPSCALER_ASSERT_SVH
`define MONO_PAGE_FRAME_TO_RGB565_UPSCALER_ASSERT_SVH

`ifndef SYNTHESIS
`define MPFU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MPFU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPFU_ASSERT(label, clk, rst, prop, msg)
`define MPFU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== sv/mpfu_pkg.sv =====
// Package with the widths, codes and types of the frame upscaler.
package mpfu_pkg;

   localparam int COLOR_W    = 16;
   localparam int SCALE_W    = 3;
   localparam int INDEX_W    = 10;
   localparam int BYTE_W     = 8;
   localparam int BIT_SEL_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 2'd2;

   localparam logic [COLOR_W-1:0] FG_COLOR_RESET = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 16'h0000;
   localparam logic [SCALE_W-1:0] SCALE_RESET    = 3'd2;

   typedef struct packed {
      logic [BIT_SEL_W-1:0] bit_sel;
      logic                 end_of_row;
      logic                 end_of_frame;
   } pixel_pos_type;

endpackage

// ===== sv/mpfu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mpfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mpfu_raster.sv =====
// Raster counters of the scaled frame with frame-store address generation.
module mpfu_raster import mpfu_pkg::*; #(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 64,
   parameter int MAX_UPSCALE  = 4,
   parameter int ADDR_W       = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [SCALE_W-1:0]  scale,
   output logic [ADDR_W-1:0]   rd_addr,
   output pixel_pos_type       pos
);

   localparam int COL_W = $clog2(FRAME_WIDTH);
   localparam int ROW_W = $clog2(FRAME_HEIGHT);
   localparam int REP_W = (MAX_UPSCALE > 1) ? $clog2(MAX_UPSCALE) : 1;
   localparam int CMP_W = SCALE_W + 1;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [REP_W-1:0] col_rep_ff, col_rep_in;
   logic [REP_W-1:0] row_rep_ff, row_rep_in;

   logic [CMP_W-1:0] used_scale;
   logic [CMP_W-1:0] last_rep;
   logic             last_col_rep;
   logic             last_row_rep;
   logic             last_col;
   logic             last_row;
   logic [ADDR_W-1:0] page;

   always_comb begin
      used_scale = CMP_W'(scale);
      if (used_scale == '0) begin
         used_scale = CMP_W'(1);
      end else if (used_scale > CMP_W'(MAX_UPSCALE)) begin
         used_scale = CMP_W'(MAX_UPSCALE);
      end
   end

   assign last_rep     = used_scale - CMP_W'(1);
   assign last_col_rep = CMP_W'(col_rep_ff) >= last_rep;
   assign last_row_rep = CMP_W'(row_rep_ff) >= last_rep;
   assign last_col     = col_ff == COL_W'(FRAME_WIDTH - 1);
   assign last_row     = row_ff == ROW_W'(FRAME_HEIGHT - 1);

   assign page    = ADDR_W'(row_ff >> 3);
   assign rd_addr = ADDR_W'(page * ADDR_W'(FRAME_WIDTH)) + ADDR_W'(col_ff);

   assign pos.bit_sel      = row_ff[BIT_SEL_W-1:0];
   assign pos.end_of_row   = last_col && last_col_rep;
   assign pos.end_of_frame = last_col && last_col_rep && last_row && last_row_rep;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      col_rep_in = col_rep_ff;
      row_rep_in = row_rep_ff;
      if (step) begin
         if (!last_col_rep) begin
            col_rep_in = col_rep_ff + REP_W'(1);
         end else begin
            col_rep_in = '0;
            if (!last_col) begin
               col_in = col_ff + COL_W'(1);
            end else begin
               col_in = '0;
               if (!last_row_rep) begin
                  row_rep_in = row_rep_ff + REP_W'(1);
               end else begin
                  row_rep_in = '0;
                  row_in     = last_row ? '0 : row_ff + ROW_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         col_rep_ff <= '0;
         row_rep_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         col_rep_ff <= col_rep_in;
         row_rep_ff <= row_rep_in;
      end
   end

endmodule

// ===== sv/mono_page_frame_to_rgb565_upscaler.sv =====
// Top level of the page-layout monochrome frame to RGB565 upscaler.
//
//   Channel  Ports                        Moves
//   req      req_valid / req_stall        one frame byte load or one pixel tick
//   rsp      rsp_valid / rsp_stall        one RGB565 pixel with row and frame marks
//   csr      csr_write / csr_index        one register write, no read-back
//
// One item is taken per clock unless stalled; pixels pass the read stage, then rsp.
// The single frame-store read port, used once per pixel tick, sets that rate.
// Loads produce no transfer on rsp and take effect for ticks in the next cycle.
// Reset clears the counters, CSRs and valid flags; the frame store is not cleared.
// A stall on rsp fills the read stage, after which req is stalled.
`include "mono_page_frame_to_rgb565_upscaler_assert.svh"
module mono_page_frame_to_rgb565_upscaler import mpfu_pkg::*; #(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 64,
   parameter int MAX_UPSCALE  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [INDEX_W-1:0]    req_byte_index,
   input  logic [BYTE_W-1:0]     req_byte_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   output logic                  rsp_end_of_row,
   output logic                  rsp_end_of_frame,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PAGE_COUNT  = (FRAME_HEIGHT + 7) / 8;
   localparam int STORE_DEPTH = FRAME_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic [COLOR_W-1:0] fg_color_ff, fg_color_in;
   logic [COLOR_W-1:0] bg_color_ff, bg_color_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;

   logic              s1_valid_ff, s1_valid_in;
   pixel_pos_type     s1_pos_ff, s1_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic              rsp_eor_ff, rsp_eor_in;
   logic              rsp_eof_ff, rsp_eof_in;

   logic              out_free;
   logic              s1_free;
   logic              accept;
   logic              pixel_accept;
   logic              load_write;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   pixel_pos_type     pos;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_free      = !s1_valid_ff || out_free;
   assign req_stall    = !s1_free;
   assign accept       = req_valid && !req_stall;
   assign pixel_accept = accept && (req_action == ACTION_PIXEL);
   assign load_write   = accept && (req_action == ACTION_LOAD)
                         && (32'(req_byte_index) < 32'(STORE_DEPTH));

   mpfu_raster #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .MAX_UPSCALE  (MAX_UPSCALE),
      .ADDR_W       (ADDR_W)
   ) u_raster (
      .clock   (clock),
      .reset   (reset),
      .step    (pixel_accept),
      .scale   (scale_ff),
      .rd_addr (rd_addr),
      .pos     (pos)
   );

   mpfu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (load_write),
      .wr_addr (ADDR_W'(req_byte_index)),
      .wr_data (req_byte_value),
      .rd_en   (pixel_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      fg_color_in = fg_color_ff;
      bg_color_in = bg_color_ff;
      scale_in    = scale_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_color_in = csr_wdata[COLOR_W-1:0];
            CSR_BG_COLOR: bg_color_in = csr_wdata[COLOR_W-1:0];
            CSR_SCALE:    scale_in    = csr_wdata[SCALE_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_pos_in    = s1_pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_eor_in   = rsp_eor_ff;
      rsp_eof_in   = rsp_eof_ff;
      if (s1_free) begin
         s1_valid_in = pixel_accept;
         s1_pos_in   = pos;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
         rsp_color_in = rd_data[s1_pos_ff.bit_sel] ? fg_color_ff : bg_color_ff;
         rsp_eor_in   = s1_pos_ff.end_of_row;
         rsp_eof_in   = s1_pos_ff.end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff  <= FG_COLOR_RESET;
         bg_color_ff  <= BG_COLOR_RESET;
         scale_ff     <= SCALE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fg_color_ff  <= fg_color_in;
         bg_color_ff  <= bg_color_in;
         scale_ff     <= scale_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff    <= s1_pos_in;
      rsp_color_ff <= rsp_color_in;
      rsp_eor_ff   <= rsp_eor_in;
      rsp_eof_ff   <= rsp_eof_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_color  = rsp_color_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   // A pixel tick transfer always occupies the read stage in the next cycle.
   `MPFU_ASSERT(a_tick_fills_stage, clock, reset, pixel_accept |=> s1_valid_ff, "pixel tick lost")
   // A full read stage behind a blocked result must hold off new items.
   `MPFU_ASSERT(a_stall_when_full, clock, reset, (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall, "item accepted into a full pipeline")
   // The frame mark only ever comes with the row mark.
   `MPFU_ASSERT(a_eof_has_eor, clock, reset, (rsp_valid_ff && rsp_eof_ff) |-> rsp_eor_ff, "end of frame without end of row")
   // A load transfer never produces a result in the read stage.
   `MPFU_ASSERT(a_load_no_result, clock, reset, (accept && (req_action == ACTION_LOAD)) |=> !s1_valid_ff, "load produced a pixel")

endmodule

// ===== verif/mono_page_frame_to_rgb565_upscaler_checker.sv =====
// Checker that predicts the upscaled pixel stream and compares it with the block's output.
module mono_page_frame_to_rgb565_upscaler_checker import mpfu_pkg::*; #(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 64,
   parameter int MAX_UPSCALE  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_action,
   input  logic [INDEX_W-1:0]    req_byte_index,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [COLOR_W-1:0]    rsp_pixel_color,
   input  logic                  rsp_end_of_row,
   input  logic                  rsp_end_of_frame,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count
);

   localparam int STORE_DEPTH = FRAME_WIDTH * ((FRAME_HEIGHT + 7) / 8);
   localparam int COL_W = $clog2(FRAME_WIDTH);
   localparam int ROW_W = $clog2(FRAME_HEIGHT);
   localparam int REP_W = (MAX_UPSCALE > 1) ? $clog2(MAX_UPSCALE) : 1;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               end_of_row;
      logic               end_of_frame;
   } scaled_pixel_type;

   logic [BYTE_W-1:0]  frame_mem [STORE_DEPTH];
   logic [COL_W-1:0]   src_col;
   logic [REP_W-1:0]   col_rep;
   logic [ROW_W-1:0]   src_row;
   logic [REP_W-1:0]   row_rep;
   logic [COLOR_W-1:0] fg_reg;
   logic [COLOR_W-1:0] bg_reg;
   logic [SCALE_W-1:0] scale_reg;

   scaled_pixel_type expected_pixels [$];
   scaled_pixel_type want;
   scaled_pixel_type next_px;
   int               mismatches = 0;
   int               waiting = 0;

   assign error_count   = mismatches;
   assign pending_count = waiting;

   function automatic int unsigned active_scale();
      if (scale_reg == 0) return 1;
      if (scale_reg > MAX_UPSCALE) return MAX_UPSCALE;
      return 32'(scale_reg);
   endfunction

   task automatic scan_next_pixel(output scaled_pixel_type px);
      int unsigned       s;
      int unsigned       addr;
      logic [BYTE_W-1:0] column_bits;
      logic              last_col;
      logic              last_row;
      s           = active_scale();
      addr        = (src_row / 8) * FRAME_WIDTH + src_col;
      column_bits = frame_mem[addr];
      px.color    = column_bits[src_row % 8] ? fg_reg : bg_reg;
      last_col    = (col_rep >= s - 1);
      last_row    = (row_rep >= s - 1);
      px.end_of_row   = (src_col == FRAME_WIDTH - 1) && last_col;
      px.end_of_frame = px.end_of_row && (src_row == FRAME_HEIGHT - 1) && last_row;
      if (!last_col) begin
         col_rep = col_rep + 1'b1;
      end else begin
         col_rep = '0;
         if (src_col < FRAME_WIDTH - 1) begin
            src_col = src_col + 1'b1;
         end else begin
            src_col = '0;
            if (!last_row) begin
               row_rep = row_rep + 1'b1;
            end else begin
               row_rep = '0;
               if (src_row < FRAME_HEIGHT - 1) src_row = src_row + 1'b1;
               else src_row = '0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         src_col   = '0;
         col_rep   = '0;
         src_row   = '0;
         row_rep   = '0;
         fg_reg    = FG_COLOR_RESET;
         bg_reg    = BG_COLOR_RESET;
         scale_reg = SCALE_RESET;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel transfer: color %h eor %b eof %b", $time,
                        rsp_pixel_color, rsp_end_of_row, rsp_end_of_frame);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_color !== want.color) begin
                  $display("%0t: pixel_color expected %h actual %h", $time,
                           want.color, rsp_pixel_color);
                  mismatches++;
               end
               if (rsp_end_of_row !== want.end_of_row) begin
                  $display("%0t: end_of_row expected %b actual %b", $time,
                           want.end_of_row, rsp_end_of_row);
                  mismatches++;
               end
               if (rsp_end_of_frame !== want.end_of_frame) begin
                  $display("%0t: end_of_frame expected %b actual %b", $time,
                           want.end_of_frame, rsp_end_of_frame);
                  mismatches++;
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_FG_COLOR: fg_reg = csr_wdata[COLOR_W-1:0];
               CSR_BG_COLOR: bg_reg = csr_wdata[COLOR_W-1:0];
               CSR_SCALE:    scale_reg = csr_wdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACTION_LOAD) begin
               if (req_byte_index < STORE_DEPTH) frame_mem[req_byte_index] = req_byte_value;
            end else begin
               scan_next_pixel(next_px);
               expected_pixels.push_back(next_px);
            end
         end
      end
      waiting = expected_pixels.size();
   end

endmodule

// ===== verif/mono_page_frame_to_rgb565_upscaler_tb.sv =====
// Testbench top that drives loads, pixel ticks and register writes into the upscaler.
module mono_page_frame_to_rgb565_upscaler_tb;
   import mpfu_pkg::*;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int STORE_DEPTH  = 1024;
   localparam int PAGE_BYTES   = 128;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACTION_LOAD;
   logic [INDEX_W-1:0]    req_byte_index = '0;
   logic [BYTE_W-1:0]     req_byte_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  rsp_end_of_row;
   logic                  rsp_end_of_frame;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int   failures;
   int   pending;
   int   cycle_count = 0;
   logic gapless = 1'b0;
   logic hold_req = 1'b0;

   mono_page_frame_to_rgb565_upscaler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_byte_index(req_byte_index), .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pixel_color(rsp_pixel_color),
      .rsp_end_of_row(rsp_end_of_row), .rsp_end_of_frame(rsp_end_of_frame),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   mono_page_frame_to_rgb565_upscaler_checker pixel_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_byte_index(req_byte_index), .req_byte_value(req_byte_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pixel_color(rsp_pixel_color),
      .rsp_end_of_row(rsp_end_of_row), .rsp_end_of_frame(rsp_end_of_frame),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(failures), .pending_count(pending)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gapless || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [COLOR_W-1:0] rand_color();
      return COLOR_W'($urandom_range(0, 65535));
   endfunction

   task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_action     <= act;
      req_byte_index <= idx;
      req_byte_value <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_look(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                           input logic [CSR_DATA_W-1:0] scale_word);
      wait_drained();
      write_reg(CSR_FG_COLOR, fg);
      write_reg(CSR_BG_COLOR, bg);
      write_reg(CSR_SCALE, scale_word);
   endtask

   task automatic pixel_burst(input int tick_target, input int load_pct);
      int ticks;
      int n;
      logic [INDEX_W-1:0] idx;
      logic [BYTE_W-1:0]  val;
      ticks = 0;
      n = 0;
      while (ticks < tick_target) begin
         if (n % 40 == 0) gapless = ($urandom_range(0, 3) == 0);
         n++;
         idx = INDEX_W'($urandom_range(0, STORE_DEPTH - 1));
         val = BYTE_W'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < load_pct) begin
            send_item(ACTION_LOAD, idx, val);
         end else begin
            send_item(ACTION_PIXEL, idx, val);
            ticks++;
         end
         if ($urandom_range(0, 199) == 0) wait_drained();
      end
      gapless = 1'b0;
   endtask

   initial begin
      int r;
      int run;
      logic level;
      forever begin
         if (hold_req) begin
            level    = 1'b1;
            run      = HOLD_CYCLES;
            hold_req = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               level = 1'b0;
               run   = $urandom_range(1, 6);
            end else if (r < 85) begin
               level = 1'b1;
               run   = $urandom_range(1, 3);
            end else if (r < 95) begin
               level = 1'b1;
               run   = $urandom_range(15, 40);
            end else begin
               level = 1'b0;
               run   = $urandom_range(60, 150);
            end
         end
         @(negedge clock);
         rsp_stall <= level;
         repeat (run - 1) @(negedge clock);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [BYTE_W-1:0] fill;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the top page first; the pixel ticks below never leave its eight rows.
      for (int i = 0; i < PAGE_BYTES; i++) begin
         case (i % 97)
            0:       fill = 8'h00;
            1:       fill = 8'hFF;
            2:       fill = 8'h01;
            3:       fill = 8'h80;
            default: fill = BYTE_W'($urandom_range(0, 255));
         endcase
         send_item(ACTION_LOAD, INDEX_W'(i), fill);
      end

      // Directed checks at the reset colors and scale, then at scale one with swapped extremes.
      send_item(ACTION_LOAD, 10'd0, 8'hFF);
      send_item(ACTION_LOAD, 10'd1, 8'h00);
      send_item(ACTION_LOAD, 10'd2, 8'h80);
      send_item(ACTION_LOAD, 10'd3, 8'h01);
      send_item(ACTION_LOAD, 10'd127, 8'h81);
      send_item(ACTION_LOAD, 10'd512, 8'h55);
      send_item(ACTION_LOAD, INDEX_W'(STORE_DEPTH - 1), 8'hFF);
      repeat (8) send_item(ACTION_PIXEL, '0, 8'h00);
      set_look(16'h0000, 16'hFFFF, 16'd1);
      send_item(ACTION_LOAD, 10'd4, 8'hAA);
      repeat (6) send_item(ACTION_PIXEL, INDEX_W'(STORE_DEPTH - 1), 8'hFF);

      set_look(16'h0000, 16'hFFFF, 16'd1);
      pixel_burst(70, 30);

      set_look(16'hF800, 16'h07E0, 16'd4);
      hold_req = 1'b1;
      gapless  = 1'b1;
      pixel_burst(70, 10);

      set_look(rand_color(), rand_color(), 16'd0);
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 65535)));
      pixel_burst(70, 30);

      set_look(rand_color(), rand_color(), 16'hFFFF);
      pixel_burst(70, 30);

      set_look(rand_color(), rand_color(), 16'd3);
      pixel_burst(70, 30);

      set_look(16'hFFFF, 16'h0000, 16'd5);
      pixel_burst(70, 30);

      set_look(rand_color(), rand_color(), 16'd2);
      pixel_burst(70, 30);

      wait_drained();
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
